@@ rtl/osd_pkg.sv @@
`default_nettype none

package osd_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int DIST_BITS_DEF = 16;

    localparam int RAW_BITS   = 16;
    localparam int NOW_BITS   = 32;
    localparam int WIN_BITS   = 10;
    localparam int MARGIN_BITS = 8;
    localparam int HOLD_BITS  = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [HOLD_BITS-1:0] STOP_HOLD_MS  = HOLD_BITS'(80);
    localparam logic [HOLD_BITS-1:0] FWD_HOLD_MS   = HOLD_BITS'(90);
    localparam logic [HOLD_BITS-1:0] NUDGE_HOLD_MS = HOLD_BITS'(5);

    typedef enum logic [1:0] {
        CMD_STOP  = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_LEFT  = 2'd2,
        CMD_RIGHT = 2'd3
    } drive_cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VALID_MIN     = 3'd0,
        REG_VALID_MAX     = 3'd1,
        REG_STOP_DISTANCE = 3'd2,
        REG_FORWARD_BONUS = 3'd3,
        REG_SWITCH_HYST   = 3'd4,
        REG_WALL_NEAR     = 3'd5,
        REG_WALL_MARGIN   = 3'd6,
        REG_TURN_HOLD     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [WIN_BITS-1:0]    valid_min;
        logic [WIN_BITS-1:0]    valid_max;
        logic [WIN_BITS-1:0]    stop_distance;
        logic [MARGIN_BITS-1:0] forward_bonus;
        logic [MARGIN_BITS-1:0] switch_hysteresis;
        logic [MARGIN_BITS-1:0] wall_near;
        logic [MARGIN_BITS-1:0] wall_margin;
        logic [HOLD_BITS-1:0]   turn_hold_ms;
    } osd_cfg_t;

    localparam osd_cfg_t CFG_RESET = '{
        valid_min:         WIN_BITS'(3),
        valid_max:         WIN_BITS'(300),
        stop_distance:     WIN_BITS'(23),
        forward_bonus:     MARGIN_BITS'(15),
        switch_hysteresis: MARGIN_BITS'(15),
        wall_near:         MARGIN_BITS'(13),
        wall_margin:       MARGIN_BITS'(5),
        turn_hold_ms:      HOLD_BITS'(130)
    };

endpackage

`default_nettype wire

@@ rtl/osd_cfg_regs.sv @@
`default_nettype none

module osd_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    input  wire logic [osd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [osd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output osd_pkg::osd_cfg_t                       cfg
);
    import osd_pkg::*;

    osd_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_VALID_MIN:     cfg_next.valid_min         = cfg_data[WIN_BITS-1:0];
                REG_VALID_MAX:     cfg_next.valid_max         = cfg_data[WIN_BITS-1:0];
                REG_STOP_DISTANCE: cfg_next.stop_distance     = cfg_data[WIN_BITS-1:0];
                REG_FORWARD_BONUS: cfg_next.forward_bonus     = cfg_data[MARGIN_BITS-1:0];
                REG_SWITCH_HYST:   cfg_next.switch_hysteresis = cfg_data[MARGIN_BITS-1:0];
                REG_WALL_NEAR:     cfg_next.wall_near         = cfg_data[MARGIN_BITS-1:0];
                REG_WALL_MARGIN:   cfg_next.wall_margin       = cfg_data[MARGIN_BITS-1:0];
                REG_TURN_HOLD:     cfg_next.turn_hold_ms      = cfg_data[HOLD_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/osd_decide.sv @@
`default_nettype none

module osd_decide #(
    parameter int TIME_BITS = osd_pkg::TIME_BITS_DEF,
    parameter int DIST_BITS = osd_pkg::DIST_BITS_DEF
) (
    input  wire osd_pkg::osd_cfg_t             cfg,
    input  wire logic [osd_pkg::RAW_BITS-1:0]  left_raw,
    input  wire logic [osd_pkg::RAW_BITS-1:0]  front_raw,
    input  wire logic [osd_pkg::RAW_BITS-1:0]  right_raw,
    input  wire logic [osd_pkg::NOW_BITS-1:0]  time_ms,
    input  wire osd_pkg::drive_cmd_t           held_dir,
    input  wire logic [TIME_BITS-1:0]          deadline,
    output osd_pkg::drive_cmd_t                cmd,
    output osd_pkg::drive_cmd_t                held_dir_new,
    output logic [TIME_BITS-1:0]               deadline_new
);
    import osd_pkg::*;

    localparam int SW = DIST_BITS + 1;

    function automatic logic [DIST_BITS-1:0] clean_dist(
        input logic [RAW_BITS-1:0] raw,
        input logic [WIN_BITS-1:0] vmin,
        input logic [WIN_BITS-1:0] vmax
    );
        logic in_win;
        in_win = (raw >= RAW_BITS'(vmin)) && (raw <= RAW_BITS'(vmax));
        return in_win ? raw[DIST_BITS-1:0] : '0;
    endfunction

    logic [DIST_BITS-1:0] dl, df, dr;
    logic [DIST_BITS-1:0] bv_left, best_val, cur_val;
    logic [TIME_BITS-1:0] now;
    logic [SW-1:0]        df_bonus, cur_hyst, dl_margin, dr_margin;
    logic                 in_hold, front_blocked, left_ok, right_ok, keep_held;
    logic                 nudge_right, nudge_left;
    drive_cmd_t           best, chosen;
    logic [HOLD_BITS-1:0] span;

    assign dl  = clean_dist(left_raw,  cfg.valid_min, cfg.valid_max);
    assign df  = clean_dist(front_raw, cfg.valid_min, cfg.valid_max);
    assign dr  = clean_dist(right_raw, cfg.valid_min, cfg.valid_max);
    assign now = TIME_BITS'(time_ms);

    assign in_hold       = now < deadline;
    assign front_blocked = (df == '0) || (SW'(df) <= SW'(cfg.stop_distance));

    // widest direction with forward bonus
    assign df_bonus = SW'(df) + SW'(cfg.forward_bonus);
    assign left_ok  = (dl != '0) && (SW'(dl) > df_bonus) && (dl > df);
    assign bv_left  = left_ok ? dl : df;
    assign right_ok = (dr != '0) && (SW'(dr) > df_bonus) && (dr > bv_left);
    assign best_val = right_ok ? dr : bv_left;

    always_comb begin
        priority if (right_ok) best = CMD_RIGHT;
        else if (left_ok)      best = CMD_LEFT;
        else                   best = CMD_FWD;
    end

    always_comb begin
        unique case (held_dir)
            CMD_FWD:  cur_val = df;
            CMD_LEFT: cur_val = dl;
            default:  cur_val = dr;
        endcase
        if (cur_val == '0) cur_val = DIST_BITS'(1);
    end

    // hold the current direction unless the new one wins by the hysteresis
    assign cur_hyst  = SW'(cur_val) + SW'(cfg.switch_hysteresis);
    assign keep_held = (best != held_dir) && (SW'(best_val) < cur_hyst);

    always_comb begin
        chosen = keep_held ? held_dir : best;
        if (chosen == CMD_STOP) chosen = CMD_RIGHT;
    end

    assign dl_margin   = SW'(dl) + SW'(cfg.wall_margin);
    assign dr_margin   = SW'(dr) + SW'(cfg.wall_margin);
    assign nudge_right = (dl != '0) && (dr != '0) && (SW'(dl) < SW'(cfg.wall_near))
                         && (SW'(dr) > dl_margin);
    assign nudge_left  = (dl != '0) && (dr != '0) && (SW'(dr) < SW'(cfg.wall_near))
                         && (SW'(dl) > dr_margin);

    always_comb begin
        cmd          = CMD_FWD;
        held_dir_new = held_dir;
        span         = cfg.turn_hold_ms;
        priority if (in_hold) begin
            cmd = (held_dir == CMD_FWD || held_dir == CMD_LEFT) ? held_dir : CMD_RIGHT;
        end else if (front_blocked) begin
            if (dl == '0 && dr == '0) begin
                cmd          = CMD_STOP;
                held_dir_new = CMD_FWD;
                span         = STOP_HOLD_MS;
            end else begin
                cmd          = (dr >= dl) ? CMD_RIGHT : CMD_LEFT;
                held_dir_new = cmd;
            end
        end else if (chosen == CMD_FWD) begin
            priority if (nudge_right) begin
                cmd  = CMD_RIGHT;
                span = NUDGE_HOLD_MS;
            end else if (nudge_left) begin
                cmd  = CMD_LEFT;
                span = NUDGE_HOLD_MS;
            end else begin
                cmd  = CMD_FWD;
                span = FWD_HOLD_MS;
            end
            held_dir_new = cmd;
        end else begin
            cmd          = chosen;
            held_dir_new = chosen;
        end
    end

    assign deadline_new = in_hold ? deadline : now + TIME_BITS'(span);

endmodule

`default_nettype wire

@@ rtl/obstacle_steering_decider_unit.sv @@
`default_nettype none

// An accepted input word passes through the input register and then the result register;
// m_tvalid rises once the staged word advances into the result register.
// Throughput: one word per cycle unless m_tready stalls the output; decision and state update together.
// The held direction and hold deadline loop through the decision logic once per word.
// Reset (aresetn low, synchronous): both stages empty, configuration to defaults,
// held direction forward, hold deadline zero.
module obstacle_steering_decider_unit #(
    parameter int TIME_BITS = osd_pkg::TIME_BITS_DEF,
    parameter int DIST_BITS = osd_pkg::DIST_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // left_raw[15:0], front_raw[31:16], right_raw[47:32], time_ms[79:48]
    input  wire logic [79:0]                        s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // drive_command[1:0], zeros[7:2]
    output logic [7:0]                              m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [osd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [osd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import osd_pkg::*;

    osd_cfg_t cfg;

    logic                 in_valid_reg, in_valid_next;
    logic [RAW_BITS-1:0]  left_reg, front_reg, right_reg;
    logic [NOW_BITS-1:0]  time_reg;
    logic                 out_valid_reg, out_valid_next;
    drive_cmd_t           cmd_reg, cmd;
    drive_cmd_t           held_dir_reg, held_dir_next, held_dir_new;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next, deadline_new;
    logic                 advance, s_accept;

    assign cfg_ready = 1'b1;

    osd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    osd_decide #(
        .TIME_BITS (TIME_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_decide (
        .cfg          (cfg),
        .left_raw     (left_reg),
        .front_raw    (front_reg),
        .right_raw    (right_reg),
        .time_ms      (time_reg),
        .held_dir     (held_dir_reg),
        .deadline     (deadline_reg),
        .cmd          (cmd),
        .held_dir_new (held_dir_new),
        .deadline_new (deadline_new)
    );

    // move the staged word into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);
    assign held_dir_next  = advance ? held_dir_new : held_dir_reg;
    assign deadline_next  = advance ? deadline_new : deadline_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_dir_reg  <= CMD_FWD;
            deadline_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            held_dir_reg  <= held_dir_next;
            deadline_reg  <= deadline_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            left_reg  <= s_tdata[15:0];
            front_reg <= s_tdata[31:16];
            right_reg <= s_tdata[47:32];
            time_reg  <= s_tdata[79:48];
        end
        if (advance) begin
            cmd_reg <= cmd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, cmd_reg};

    held_never_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        held_dir_reg != CMD_STOP)
        else $error("held direction is stop");

    stop_holds_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cmd == CMD_STOP) |=> (held_dir_reg == CMD_FWD))
        else $error("stop did not record forward");

    hold_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (TIME_BITS'(time_reg) < deadline_reg))
        |=> ($stable(held_dir_reg) && $stable(deadline_reg)))
        else $error("state changed inside hold window");

    staged_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("staged word dropped");

    not_ready_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with free slot");

endmodule

`default_nettype wire
